[rtl/ihc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_pkg
// Types, codes and constants shared by the IPv4 receive header check.
// ----------------------------------------------------------------------------
package ihc_pkg;

   // header geometry
   localparam int HDR_BYTES        = 20;
   localparam int HDR_INDEX_WIDTH  = $clog2(HDR_BYTES);
   localparam int COUNT_WIDTH      = 16;
   localparam int SUM_WIDTH        = 21;

   // protocol constants
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [15:0] FLAG_RESERVED   = 16'h8000;
   localparam logic [15:0] FRAG_BITS       = 16'h3FFF;
   localparam logic [7:0]  LOOPBACK_OCTET  = 8'd127;
   localparam logic [7:0]  MCAST_LOW       = 8'd224;
   localparam logic [7:0]  MCAST_HIGH      = 8'd239;
   localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam logic [3:0]  IP_VERSION      = 4'd4;
   localparam logic [3:0]  IHL_BASIC       = 4'd5;
   localparam logic [3:0]  NIBBLE_MASK     = 4'hF;
   localparam logic [15:0] SUM_GOOD        = 16'hFFFF;

   // mac destination kinds
   localparam logic [1:0] MAC_KIND_BROADCAST = 2'd1;
   localparam logic [1:0] MAC_KIND_UNICAST   = 2'd2;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOCAL_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IS_CONFIGURED = 1'd1;

   // verdict codes
   typedef enum logic [2:0] {
      VERDICT_LOCAL    = 3'd0,
      VERDICT_BCAST    = 3'd1,
      VERDICT_INVALID  = 3'd2,
      VERDICT_OPTIONS  = 3'd3,
      VERDICT_FRAGMENT = 3'd4,
      VERDICT_CHECKSUM = 3'd5,
      VERDICT_IGNORED  = 3'd6
   } verdict_type;

   typedef logic [HDR_BYTES-1:0][7:0] header_type;

   // one finished frame handed from front to back
   typedef struct packed {
      header_type              header;
      logic [COUNT_WIDTH-1:0]  length;
      logic [SUM_WIDTH-1:0]    sum;
      logic [15:0]             ether_type;
      logic [1:0]              mac_dest_kind;
      logic                    interface_match;
   } frame_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // configuration seen by the back end
   typedef struct packed {
      logic [31:0] local_address;
      logic        is_configured;
   } csr_type;

endpackage

[rtl/ihc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_req_if / ihc_rsp_if
// Valid/ready channels for payload bytes in and header verdicts out.
// ----------------------------------------------------------------------------
interface ihc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last;
   logic [15:0] ether_type;
   logic [1:0]  mac_dest_kind;
   logic        interface_match;

   modport source (output valid, data_byte, last, ether_type, mac_dest_kind,
                   interface_match, input ready);
   modport sink   (input valid, data_byte, last, ether_type, mac_dest_kind,
                   interface_match, output ready);
endinterface

interface ihc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [15:0] packet_length;
   logic [7:0]  protocol;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] ident;
   logic [7:0]  hop_limit;

   modport source (output valid, verdict, packet_length, protocol, source_address,
                   dest_address, ident, hop_limit, input ready);
   modport sink   (input valid, verdict, packet_length, protocol, source_address,
                   dest_address, ident, hop_limit, output ready);
endinterface

[rtl/ihc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_front
// Takes payload bytes, keeps the header bytes, running sum and byte count,
// and pushes a frame record into the queue on the last byte.
// ----------------------------------------------------------------------------
module ihc_front (
   input  logic                         clock,
   input  logic                         reset,
   ihc_req_if.sink                      req_chan,
   input  ihc_pkg::queue_status_type    queue_status,
   output logic                         queue_push,
   output ihc_pkg::frame_type           frame_out
);

   logic [ihc_pkg::COUNT_WIDTH-1:0] count_ff, count_in, count_inc;
   logic [ihc_pkg::SUM_WIDTH-1:0]   sum_ff, sum_in, sum_add;
   ihc_pkg::header_type             header_ff, header_in;
   logic                            in_header;
   logic                            accept;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_header      = count_ff < ihc_pkg::COUNT_WIDTH'(ihc_pkg::HDR_BYTES);

   // header bytes with the current byte dropped into place
   always_comb begin
      for (int i = 0; i < ihc_pkg::HDR_BYTES; i++) begin
         header_in[i] = (in_header && count_ff[ihc_pkg::HDR_INDEX_WIDTH-1:0] ==
                         ihc_pkg::HDR_INDEX_WIDTH'(i)) ? req_chan.data_byte : header_ff[i];
      end
   end

   // big-endian word sum: even bytes are high halves
   assign sum_add   = count_ff[0] ? ihc_pkg::SUM_WIDTH'(req_chan.data_byte)
                                  : ihc_pkg::SUM_WIDTH'({req_chan.data_byte, 8'h00});
   assign sum_in    = in_header ? sum_ff + sum_add : sum_ff;

   // saturating byte count
   assign count_inc = (count_ff == {ihc_pkg::COUNT_WIDTH{1'b1}}) ? count_ff
                      : count_ff + ihc_pkg::COUNT_WIDTH'(1);
   assign count_in  = count_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         if (req_chan.last) begin
            count_ff <= '0;
            sum_ff   <= '0;
         end else begin
            count_ff <= count_in;
            sum_ff   <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff <= header_in;
      end
   end

   // frame record on the last transfer
   assign queue_push                = accept && req_chan.last;
   assign frame_out.header          = header_in;
   assign frame_out.length          = count_in;
   assign frame_out.sum             = sum_in;
   assign frame_out.ether_type      = req_chan.ether_type;
   assign frame_out.mac_dest_kind   = req_chan.mac_dest_kind;
   assign frame_out.interface_match = req_chan.interface_match;

endmodule

[rtl/ihc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_queue
// Two-entry queue of frame records between front and back.
// ----------------------------------------------------------------------------
module ihc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  ihc_pkg::queue_ctrl_type      ctrl,
   input  ihc_pkg::frame_type           push_frame,
   output ihc_pkg::frame_type           head_frame,
   output ihc_pkg::queue_status_type    status
);

   ihc_pkg::frame_type entry_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         fill_ff, fill_in;
   logic               do_push, do_pop;

   assign status.full  = fill_ff == 2'd2;
   assign status.empty = fill_ff == 2'd0;
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;

   assign wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;

   // fill level
   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign head_frame = entry_ff[rd_ptr_ff];

endmodule

[rtl/ihc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_back
// Runs the header checks on the queue head and holds the verdict in an
// output register until the result transfer.
// ----------------------------------------------------------------------------
module ihc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ihc_pkg::frame_type           frame_in,
   input  ihc_pkg::queue_status_type    queue_status,
   input  ihc_pkg::csr_type             csr,
   output logic                         queue_pop,
   ihc_rsp_if.source                    rsp_chan
);

   ihc_pkg::verdict_type verdict_in, verdict_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 full_hdr;
   logic [3:0]           version, ihl;
   logic [15:0]          tlen, flags, ident;
   logic [7:0]           ttl, proto;
   logic [31:0]          src, dst;
   logic [16:0]          fold_once;
   logic [15:0]          fold_twice;
   logic                 src_unicast;
   logic                 class_bcast, class_local;
   logic [15:0]          tlen_ff, ident_ff;
   logic [7:0]           proto_ff, ttl_ff;
   logic [31:0]          src_ff, dst_ff;

   // header fields
   assign full_hdr = frame_in.length >= ihc_pkg::COUNT_WIDTH'(ihc_pkg::HDR_BYTES);
   assign version  = frame_in.header[0][7:4];
   assign ihl      = frame_in.header[0][3:0] & ihc_pkg::NIBBLE_MASK;
   assign tlen     = {frame_in.header[2], frame_in.header[3]};
   assign ident    = {frame_in.header[4], frame_in.header[5]};
   assign flags    = {frame_in.header[6], frame_in.header[7]};
   assign ttl      = frame_in.header[8];
   assign proto    = frame_in.header[9];
   assign src      = {frame_in.header[12], frame_in.header[13],
                      frame_in.header[14], frame_in.header[15]};
   assign dst      = {frame_in.header[16], frame_in.header[17],
                      frame_in.header[18], frame_in.header[19]};

   // end-around carry fold of the 21-bit sum
   assign fold_once  = 17'(frame_in.sum[15:0]) + 17'(frame_in.sum[20:16]);
   assign fold_twice = fold_once[15:0] + 16'(fold_once[16]);

   // source must be plain unicast
   assign src_unicast = !(src == '0 || src == ihc_pkg::ALL_ONES ||
                          src[31:24] == ihc_pkg::LOOPBACK_OCTET ||
                          (src[31:24] >= ihc_pkg::MCAST_LOW &&
                           src[31:24] <= ihc_pkg::MCAST_HIGH));

   assign class_bcast = frame_in.mac_dest_kind == ihc_pkg::MAC_KIND_BROADCAST &&
                        dst == ihc_pkg::ALL_ONES && proto == ihc_pkg::PROTO_UDP;
   assign class_local = csr.is_configured && frame_in.interface_match &&
                        frame_in.mac_dest_kind == ihc_pkg::MAC_KIND_UNICAST &&
                        dst == csr.local_address;

   // checks in priority order
   always_comb begin
      if (frame_in.ether_type != ihc_pkg::ETHERTYPE_IPV4 || !full_hdr) begin
         verdict_in = ihc_pkg::VERDICT_INVALID;
      end else if (version != ihc_pkg::IP_VERSION || ihl < ihc_pkg::IHL_BASIC) begin
         verdict_in = ihc_pkg::VERDICT_INVALID;
      end else if (ihl != ihc_pkg::IHL_BASIC) begin
         verdict_in = ihc_pkg::VERDICT_OPTIONS;
      end else if (tlen < 16'(ihc_pkg::HDR_BYTES) || tlen > frame_in.length ||
                   ttl == '0) begin
         verdict_in = ihc_pkg::VERDICT_INVALID;
      end else if ((flags & ihc_pkg::FLAG_RESERVED) != '0) begin
         verdict_in = ihc_pkg::VERDICT_INVALID;
      end else if ((flags & ihc_pkg::FRAG_BITS) != '0) begin
         verdict_in = ihc_pkg::VERDICT_FRAGMENT;
      end else if (fold_twice != ihc_pkg::SUM_GOOD) begin
         verdict_in = ihc_pkg::VERDICT_CHECKSUM;
      end else if (!class_bcast && !class_local) begin
         verdict_in = ihc_pkg::VERDICT_IGNORED;
      end else if (!src_unicast || (csr.is_configured && src == csr.local_address)) begin
         verdict_in = ihc_pkg::VERDICT_INVALID;
      end else if (class_bcast) begin
         verdict_in = ihc_pkg::VERDICT_BCAST;
      end else begin
         verdict_in = ihc_pkg::VERDICT_LOCAL;
      end
   end

   // output register: load when empty or being drained
   assign queue_pop    = !queue_status.empty && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_valid_in = queue_pop ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         verdict_ff <= verdict_in;
         tlen_ff    <= full_hdr ? tlen  : '0;
         proto_ff   <= full_hdr ? proto : '0;
         src_ff     <= full_hdr ? src   : '0;
         dst_ff     <= full_hdr ? dst   : '0;
         ident_ff   <= full_hdr ? ident : '0;
         ttl_ff     <= full_hdr ? ttl   : '0;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.verdict        = verdict_ff;
   assign rsp_chan.packet_length  = tlen_ff;
   assign rsp_chan.protocol       = proto_ff;
   assign rsp_chan.source_address = src_ff;
   assign rsp_chan.dest_address   = dst_ff;
   assign rsp_chan.ident          = ident_ff;
   assign rsp_chan.hop_limit      = ttl_ff;

endmodule

[rtl/ipv4_rx_header_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_rx_header_check
// Receive-side IPv4 header validation, checksum and address classification.
//
//   channel   direction  handshake       carries
//   req_chan  in         valid/ready     one payload byte plus frame side info
//   rsp_chan  out        valid/ready     one verdict and header fields a frame
//   csr_*     in         write enable    local address, configured flag
//
// One byte is taken every cycle; the front only stalls when the two-entry
// frame queue is full. The last byte transfer writes the queue, and the
// output register loads from the queue head while empty or being drained, so
// one frame a cycle retires unless the result stalls. Reset is synchronous and
// clears counts, sum, queue and output valid; no clearing pass. A stalled
// result holds its register while the front keeps taking bytes until the queue fills.
// ----------------------------------------------------------------------------
module ipv4_rx_header_check (
   input  logic                                  clock,
   input  logic                                  reset,
   ihc_req_if.sink                               req_chan,
   ihc_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [ihc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ihc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);

   logic [31:0]                  local_address_ff;
   logic                         is_configured_ff;
   ihc_pkg::csr_type             csr;
   ihc_pkg::queue_ctrl_type      queue_ctrl;
   ihc_pkg::queue_status_type    queue_status;
   ihc_pkg::frame_type           push_frame, head_frame;
   logic                         queue_push, queue_pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= '0;
         is_configured_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ihc_pkg::CSR_LOCAL_ADDRESS: local_address_ff <= csr_write_data;
            ihc_pkg::CSR_IS_CONFIGURED: is_configured_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign csr.local_address = local_address_ff;
   assign csr.is_configured = is_configured_ff;

   assign queue_ctrl.push = queue_push;
   assign queue_ctrl.pop  = queue_pop;

   ihc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .queue_status (queue_status),
      .queue_push   (queue_push),
      .frame_out    (push_frame)
   );

   ihc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (queue_ctrl),
      .push_frame (push_frame),
      .head_frame (head_frame),
      .status     (queue_status)
   );

   ihc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .frame_in     (head_frame),
      .queue_status (queue_status),
      .csr          (csr),
      .queue_pop    (queue_pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

[rtl/ihc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihc_checker
// Port-level checks on the result channel of the header check.
// ----------------------------------------------------------------------------
module ihc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_verdict,
   input  logic [7:0]  rsp_protocol,
   input  logic [31:0] rsp_source_address,
   input  logic [31:0] rsp_dest_address
);

   // a waiting result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // only defined verdict codes leave the block
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict <= ihc_pkg::VERDICT_IGNORED)
      else $error("undefined verdict code");

   // limited broadcast is udp to all ones
   a_bcast_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict == ihc_pkg::VERDICT_BCAST |->
         rsp_dest_address == ihc_pkg::ALL_ONES && rsp_protocol == ihc_pkg::PROTO_UDP)
      else $error("broadcast verdict on wrong header");

   // accepted packets carry a source that is not zero, all ones or loopback
   a_accept_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == ihc_pkg::VERDICT_BCAST ||
                    rsp_verdict == ihc_pkg::VERDICT_LOCAL) |->
         rsp_source_address != '0 && rsp_source_address != ihc_pkg::ALL_ONES &&
         rsp_source_address[31:24] != ihc_pkg::LOOPBACK_OCTET)
      else $error("accepted packet with non-unicast source");

endmodule

bind ipv4_rx_header_check ihc_checker u_ihc_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_verdict        (rsp_chan.verdict),
   .rsp_protocol       (rsp_chan.protocol),
   .rsp_source_address (rsp_chan.source_address),
   .rsp_dest_address   (rsp_chan.dest_address)
);
